// File: rtl/trial_division_prime_test_macros.svh
// Assertion macros shared by the prime test RTL.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TDP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tdp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TDP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tdp: next-cycle check failed");

`endif

// File: rtl/tdp_pkg.sv
// Package with widths, constants and control and status structs of the prime test.
package tdp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

    localparam logic [CNT_W-1:0]       CNT_LOAD  = CNT_W'(VALUE_WIDTH);
    localparam logic [CNT_W-1:0]       CNT_LAST  = CNT_W'(1);
    localparam logic [CNT_W-1:0]       CNT_ZERO  = '0;
    localparam logic [VALUE_WIDTH-1:0] VAL_TWO   = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] VAL_FOUR  = VALUE_WIDTH'(4);
    localparam logic [VALUE_WIDTH-1:0] D_FIRST   = VALUE_WIDTH'(3);
    localparam logic [VALUE_WIDTH-1:0] D_STEP    = VALUE_WIDTH'(2);

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/tdp_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`include "trial_division_prime_test_macros.svh"

module tdp_serial_div
    import tdp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_div_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output t_div_stat              o_stat,
    output logic [VALUE_WIDTH-1:0] o_quo,
    output logic [VALUE_WIDTH-1:0] o_rem
);

    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_done, n_done;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   busy;

    assign busy  = (r_cnt != CNT_ZERO);
    assign trial = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, i_divisor};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_quo = i_dividend;
            n_rem = '0;
            n_cnt = CNT_LOAD;
        end else if (busy) begin
            // shift in one dividend bit, subtract if it fits
            if (!diff[VALUE_WIDTH]) begin
                n_rem = diff[VALUE_WIDTH-1:0];
                n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = trial[VALUE_WIDTH-1:0];
                n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b0};
            end
            n_cnt  = r_cnt - CNT_LAST;
            n_done = (r_cnt == CNT_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= CNT_ZERO;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_stat.busy = busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

    `TDP_ASSERT_IMP(a_no_restart_busy, i_clk, i_rst_n, i_ctl.start, !busy)
    `TDP_ASSERT_NXT(a_start_runs, i_clk, i_rst_n, i_ctl.start, busy && !r_done)

endmodule

// File: rtl/trial_division_prime_test.sv
// Top level of the trial-division prime test.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-------------
//  input   | i_in_valid | o_in_stall  | i_value
//  output  | o_out_valid| i_out_stall | o_prime_flag
//
// Values below 4 and even values skip the divider and go from S_IDLE straight to S_HOLD.
// Odd values run the bit-serial divider once per odd divisor tried, k divisors in all
// (up to about 2^(VALUE_WIDTH/2-1)), until one divides the value or exceeds n/d.
// One item is worked on at a time; input is taken only when the block is idle.
// The output register holds a result under stall; the next item may be accepted then.
// Reset (synchronous, active low) clears the controller and drops any pending item.
`include "trial_division_prime_test_macros.svh"

module trial_division_prime_test
    import tdp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_prime_flag
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_n, n_n;
    logic [VALUE_WIDTH-1:0] r_d, n_d;
    logic                   r_res, n_res;
    logic                   r_start, n_start;
    logic                   r_out_valid, n_out_valid;
    logic                   r_flag, n_flag;
    logic                   slot_free;

    t_div_ctl               div_ctl;
    t_div_stat              div_stat;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;

    assign div_ctl.start = r_start;

    tdp_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_stat     (div_stat),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_res       = r_res;
        n_start     = 1'b0;
        n_out_valid = r_out_valid;
        n_flag      = r_flag;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n = i_value;
                    n_d = D_FIRST;
                    priority if (i_value < VAL_TWO) begin
                        n_res   = 1'b0;
                        n_state = S_HOLD;
                    end else if (i_value < VAL_FOUR) begin
                        n_res   = 1'b1;
                        n_state = S_HOLD;
                    end else if (!i_value[0]) begin
                        n_res   = 1'b0;
                        n_state = S_HOLD;
                    end else begin
                        n_start = 1'b1;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (div_stat.done) begin
                    // divisor past n/d means no factor remains
                    priority if (r_d > div_quo) begin
                        n_res   = 1'b1;
                        n_state = S_HOLD;
                    end else if (div_rem == '0) begin
                        n_res   = 1'b0;
                        n_state = S_HOLD;
                    end else begin
                        n_d     = r_d + D_STEP;
                        n_start = 1'b1;
                    end
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_flag      = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
        r_n    <= n_n;
        r_d    <= n_d;
        r_res  <= n_res;
        r_flag <= n_flag;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_prime_flag = r_flag;

    `TDP_ASSERT_IMP(a_div_only_in_run, i_clk, i_rst_n, div_stat.busy || div_stat.done,
        r_state == S_RUN)
    `TDP_ASSERT_IMP(a_odd_divisor, i_clk, i_rst_n, r_state == S_RUN, r_d[0] && r_n[0])

endmodule

// File: tb/testbench.sv
// Testbench for the trial-division prime test: random and corner values against a scoreboard.
`timescale 1ns / 1ps

module testbench
    import tdp_pkg::*;
();

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [VALUE_WIDTH-1:0] i_value;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_prime_flag;

    bit hold_request = 1'b0;

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        bit                     prime;
    } t_expected_flag;

    class prime_flag_scoreboard;
        t_expected_flag expected_flags[$];
        int             errors = 0;

        function bit prime_by_division(logic [VALUE_WIDTH-1:0] n);
            longint unsigned num;
            longint unsigned d;
            num = 64'(n);
            if (num < 2) return 1'b0;
            if (num < 4) return 1'b1;
            if (num[0] == 1'b0) return 1'b0;
            for (d = 3; d <= num / d; d += 2) begin
                if (num % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_value(logic [VALUE_WIDTH-1:0] v);
            t_expected_flag e;
            e.value = v;
            e.prime = prime_by_division(v);
            expected_flags.push_back(e);
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction

        task report_mismatch(string what);
            $display("prime check mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_flag(logic flag);
            t_expected_flag e;
            if (expected_flags.size() == 0) begin
                report_mismatch($sformatf("flag %b with no item outstanding", flag));
            end else begin
                e = expected_flags.pop_front();
                if (flag !== e.prime)
                    report_mismatch($sformatf("value %0d: flag %b, expected %b",
                                              e.value, flag, e.prime));
            end
        endtask
    endclass

    prime_flag_scoreboard flags = new();

    logic [VALUE_WIDTH-1:0] corner_values [0:22] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9, 32'd11, 32'd15,
        32'd25, 32'd49, 32'd97, 32'd121, 32'd65537, 32'd16777213, 32'd16777207,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
        32'h5555_5555, 32'hAAAA_AAAA
    };

    trial_division_prime_test uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_prime_flag (o_prime_flag)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

    // Offer one item and hold it until the block takes it.
    task push_value(logic [VALUE_WIDTH-1:0] v, bit allow_gap);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (!allow_gap || pick < 50)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        flags.note_value(v);
    endtask

    // Draw a value: mostly small or medium, large ones are even or carry a small odd
    // factor (3 to 13) so that the division loop ends early.
    function logic [VALUE_WIDTH-1:0] random_value();
        int                     kind;
        logic [VALUE_WIDTH-1:0] r;
        logic [VALUE_WIDTH-1:0] f;
        kind = $urandom_range(0, 99);
        if (kind < 55)
            return $urandom_range(0, 4095);
        if (kind < 75)
            return $urandom_range(4096, 262144);
        r = $urandom;
        if (kind < 85)
            return r & ~32'd1;
        f = 2 * $urandom_range(1, 6) + 1;
        return (r / f) * f;
    endfunction

    // Receiver: random stall pattern, with one long hold on request.
    initial begin
        int pick;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (2000) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else if (pick < 92) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                end else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(30, 150)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            flags.check_flag(o_prime_flag);
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_value    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_values[k])
            push_value(corner_values[k], 1'b1);

        for (int n = 0; n < 70; n++) begin
            if (n == 30) begin
                // Back up the block: receiver holds while small items keep coming.
                hold_request = 1'b1;
                repeat (8) push_value($urandom_range(0, 255), 1'b0);
            end
            push_value(random_value(), 1'b1);
        end
        i_in_valid <= 1'b0;

        while (flags.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (flags.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/tdp_pkg.sv
rtl/tdp_serial_div.sv
rtl/trial_division_prime_test.sv
tb/testbench.sv
